FILE: rtl/c40enc_pkg.sv
// ----------------------------------------------------------------------------
// c40enc_pkg
// shared types and constants of the c40 text encoder
// ----------------------------------------------------------------------------
`default_nettype none

package c40enc_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 6;
  localparam int unsigned WordW  = 16;

  // characters of the c40 basic set
  localparam logic [CharW-1:0] CharSpace  = 8'd32;
  localparam logic [CharW-1:0] CharLess   = 8'd60;
  localparam logic [CharW-1:0] CharDigit0 = 8'd48;
  localparam logic [CharW-1:0] CharDigit9 = 8'd57;
  localparam logic [CharW-1:0] CharUpperA = 8'd65;
  localparam logic [CharW-1:0] CharUpperZ = 8'd90;

  // value mapping
  localparam logic [ValueW-1:0] ValueShift  = 6'd3;
  localparam logic [CharW-1:0]  DigitOffset = 8'd44;
  localparam logic [CharW-1:0]  UpperOffset = 8'd51;
  localparam logic [ValueW-1:0] ValueBad    = 6'd0;

  // packing
  localparam logic [WordW-1:0] MulFirst  = 16'd1600;
  localparam logic [WordW-1:0] MulSecond = 16'd40;
  localparam logic [ByteW-1:0] PadByte   = 8'd254;

  // group fill
  typedef enum logic [1:0] {
    GRP_EMPTY = 2'd0,
    GRP_ONE   = 2'd1,
    GRP_TWO   = 2'd2
  } grp_cnt_e;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CharW-1:0]  char_code;
    logic              last;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic     avail;
    q_entry_t entry;
  } q_rd_t;

endpackage

`default_nettype wire

FILE: rtl/c40enc_in_if.sv
// ----------------------------------------------------------------------------
// c40enc_in_if
// character channel: valid/ready handshake with one character per item
// ----------------------------------------------------------------------------
`default_nettype none

interface c40enc_in_if;
  import c40enc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/c40enc_out_if.sv
// ----------------------------------------------------------------------------
// c40enc_out_if
// encoded channel: valid/ready handshake with one byte pair per item
// ----------------------------------------------------------------------------
`default_nettype none

interface c40enc_out_if;
  import c40enc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] high_byte;
  logic [ByteW-1:0] low_byte;
  logic             string_done;
  logic             bad_char;

  modport source (output valid, output high_byte, output low_byte, output string_done,
                  output bad_char, input ready);
  modport sink   (input valid, input high_byte, input low_byte, input string_done,
                  input bad_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/c40enc_front.sv
// ----------------------------------------------------------------------------
// c40enc_front
// accepts characters and classifies them into c40 values for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module c40enc_front (
  c40enc_in_if.sink      char_i,
  input  logic           q_full_i,
  output c40enc_pkg::q_wr_t q_wr_o
);
  import c40enc_pkg::*;

  logic [ValueW-1:0] value;
  logic [CharW-1:0]  ch;
  logic [CharW-1:0]  diff;

  assign ch = char_i.char_code;

  // zero marks a character outside the set
  always_comb begin
    value = ValueBad;
    diff  = '0;
    if (ch == CharSpace || ch == CharLess) begin
      value = ValueShift;
    end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
      diff  = ch - DigitOffset;
      value = diff[ValueW-1:0];
    end else if (ch >= CharUpperA && ch <= CharUpperZ) begin
      diff  = ch - UpperOffset;
      value = diff[ValueW-1:0];
    end
  end

  assign char_i.ready          = ~q_full_i;
  assign q_wr_o.push            = char_i.valid & ~q_full_i;
  assign q_wr_o.entry.value     = value;
  assign q_wr_o.entry.char_code = ch;
  assign q_wr_o.entry.last      = char_i.end_of_string;

endmodule

`default_nettype wire

FILE: rtl/c40enc_queue.sv
// ----------------------------------------------------------------------------
// c40enc_queue
// small fifo of classified characters between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module c40enc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c40enc_pkg::q_wr_t q_wr_i,
  output logic              q_full_o,
  input  logic              q_pop_i,
  output c40enc_pkg::q_rd_t q_rd_o
);
  import c40enc_pkg::*;

  q_entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]     cnt_q, cnt_d;
  logic                 do_pop;

  assign q_full_o     = (cnt_q == QCntW'(QDepth));
  assign q_rd_o.avail = (cnt_q != '0);
  assign q_rd_o.entry = mem_q[rd_ptr_q];
  assign do_pop       = q_pop_i & q_rd_o.avail;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (q_wr_i.push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (q_wr_i.push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!q_wr_i.push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr_i.push) begin
      mem_q[wr_ptr_q] <= q_wr_i.entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/c40enc_back.sv
// ----------------------------------------------------------------------------
// c40enc_back
// groups c40 values, packs them into byte pairs and holds the output register
// ----------------------------------------------------------------------------
`default_nettype none

module c40enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  c40enc_pkg::q_rd_t q_rd_i,
  output logic              q_pop_o,
  c40enc_out_if.source      word_o
);
  import c40enc_pkg::*;

  grp_cnt_e          grp_q, grp_d;
  logic [ValueW-1:0] first_q, first_d;
  logic [ValueW-1:0] second_q, second_d;
  logic              failed_q, failed_d;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  high_q, high_d;
  logic [ByteW-1:0]  low_q, low_d;
  logic              done_q, done_d;
  logic              bad_q, bad_d;

  logic              emit;
  logic [WordW-1:0]  word;
  logic [ValueW-1:0] third;
  logic [CharW-1:0]  pad_char;
  q_entry_t          e;

  assign e       = q_rd_i.entry;
  // take the next item whenever the output register is free or draining
  assign q_pop_o = q_rd_i.avail & (~out_valid_q | word_o.ready);

  // third value is zero when a pair of leftovers is closed
  assign third    = (grp_q == GRP_TWO) ? e.value : ValueBad;
  assign pad_char = e.char_code + 1'b1;

  always_comb begin
    word = WordW'(first_q) * MulFirst;
    if (grp_q == GRP_TWO) begin
      word = word + WordW'(second_q) * MulSecond + WordW'(third) + 1'b1;
    end else begin
      word = word + WordW'(e.value) * MulSecond + 1'b1;
    end
  end

  always_comb begin
    grp_d    = grp_q;
    first_d  = first_q;
    second_d = second_q;
    failed_d = failed_q;
    emit     = 1'b0;
    high_d   = high_q;
    low_d    = low_q;
    done_d   = done_q;
    bad_d    = bad_q;
    if (q_pop_o) begin
      if (failed_q || e.value == ValueBad) begin
        failed_d = 1'b1;
        if (e.last) begin
          emit   = 1'b1;
          high_d = '0;
          low_d  = '0;
          done_d = 1'b1;
          bad_d  = 1'b1;
        end
      end else begin
        unique case (grp_q)
          GRP_EMPTY: begin
            first_d = e.value;
            grp_d   = GRP_ONE;
            if (e.last) begin
              emit   = 1'b1;
              high_d = PadByte;
              low_d  = pad_char;
              done_d = 1'b1;
              bad_d  = 1'b0;
            end
          end
          GRP_ONE: begin
            second_d = e.value;
            grp_d    = GRP_TWO;
            if (e.last) begin
              emit   = 1'b1;
              high_d = word[WordW-1:ByteW];
              low_d  = word[ByteW-1:0];
              done_d = 1'b1;
              bad_d  = 1'b0;
            end
          end
          GRP_TWO: begin
            emit     = 1'b1;
            high_d   = word[WordW-1:ByteW];
            low_d    = word[ByteW-1:0];
            done_d   = e.last;
            bad_d    = 1'b0;
            grp_d    = GRP_EMPTY;
            first_d  = '0;
            second_d = '0;
          end
          default: begin
            grp_d = GRP_EMPTY;
          end
        endcase
      end
      // end of string returns everything to the start
      if (e.last) begin
        grp_d    = GRP_EMPTY;
        first_d  = '0;
        second_d = '0;
        failed_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (word_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q       <= GRP_EMPTY;
      first_q     <= '0;
      second_q    <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      grp_q       <= grp_d;
      first_q     <= first_d;
      second_q    <= second_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      high_q <= high_d;
      low_q  <= low_d;
      done_q <= done_d;
      bad_q  <= bad_d;
    end
  end

  assign word_o.valid       = out_valid_q;
  assign word_o.high_byte   = high_q;
  assign word_o.low_byte    = low_q;
  assign word_o.string_done = done_q;
  assign word_o.bad_char    = bad_q;

endmodule

`default_nettype wire

FILE: rtl/c40_text_encoder_unit.sv
// ----------------------------------------------------------------------------
// c40_text_encoder_unit
// c40 text encoder: ascii characters in, packed c40 byte pairs out
// ----------------------------------------------------------------------------
// One character is taken per item, with end_of_string on the last character
// of a string. Space and '<', digits and upper-case letters are packed three
// at a time into 1600*a+40*b+c+1 and sent as a high and a low byte; two
// leftovers close with c=0, a single leftover goes out as 254 and its code
// plus one. Any other character marks the string bad: no more pairs go out
// for it, and its last character brings one item with bad_char set and both
// bytes zero. string_done flags the last result of every string. The block
// sustains one character per cycle while the output keeps up: the front
// classifies a character and writes it into a two-entry queue in the cycle
// it is accepted, and the back takes one entry per cycle whenever its output
// register is empty or being drained. A character is registered first in the
// queue, and its result then in the output register, from which it is offered. When
// the output stalls, the queue still takes up to two more characters before
// char_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module c40_text_encoder_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  c40enc_in_if.sink    char_i,
  c40enc_out_if.source word_o
);
  import c40enc_pkg::*;

  // front to queue: push strobe and classified character
  q_wr_t q_wr;
  logic  q_full;
  // queue to back: head entry and its presence
  q_rd_t q_rd;
  logic  q_pop;

  // classification, no state
  c40enc_front u_front (
    .char_i   (char_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  // decouples input acceptance from output stalls
  c40enc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_wr_i   (q_wr),
    .q_full_o (q_full),
    .q_pop_i  (q_pop),
    .q_rd_o   (q_rd)
  );

  // grouping, packing and the output register
  c40enc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_rd_i  (q_rd),
    .q_pop_o (q_pop),
    .word_o  (word_o)
  );

endmodule

`default_nettype wire
